// ===== rtl/hec_pkg.sv =====
`timescale 1ns / 1ps
package hec_pkg;
  localparam int POOL_DEPTH_D  = 256;
  localparam int TABLE_DEPTH_D = 512;
  localparam int ID_WIDTH_D    = 32;
  localparam int DATA_WIDTH_D  = 64;
  localparam int MAP_WORD_D    = 64;
  localparam logic [15:0] AGING_RESET = 16'd170;

  localparam int CMD_W    = 1;
  localparam int SLOT_W   = 8;
  localparam int PERIOD_W = 16;

  localparam logic CMD_SEARCH = 1'b0;
  localparam logic CMD_INSERT = 1'b1;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SCAN,
    ST_PROBE_RD,
    ST_PROBE_CHK,
    ST_POOL_RD,
    ST_POOL_WAIT,
    ST_COMMIT,
    ST_OUT
  } hec_state_t;

  typedef struct packed {
    logic clear_step;
    logic load;
    logic scan_step;
    logic probe_read;
    logic probe_next;
    logic pool_read;
    logic commit;
    logic out_load;
  } hec_cmd_t;

  typedef struct packed {
    logic clear_done;
    logic scan_done;
    logic probe_hit;
    logic probe_empty;
    logic probe_exhausted;
    logic is_insert;
    logic id_zero;
  } hec_status_t;
endpackage

// ===== rtl/hec_ctrl.sv =====
`timescale 1ns / 1ps
module hec_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  output logic                 out_valid,
  input  logic                 out_ready,
  input  hec_pkg::hec_status_t status,
  output hec_pkg::hec_cmd_t    cmd
);
  import hec_pkg::*;

  hec_state_t state, state_next;
  logic       out_full, out_full_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_CLEAR;
      out_full <= 1'b0;
    end else begin
      state    <= state_next;
      out_full <= out_full_next;
    end
  end

  always_comb begin
    state_next    = state;
    cmd           = '0;
    in_ready      = 1'b0;
    out_full_next = out_full;
    if (out_full && out_ready) out_full_next = 1'b0;
    unique case (state)
      ST_CLEAR: begin
        cmd.clear_step = 1'b1;
        if (status.clear_done) state_next = ST_IDLE;
      end
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = ST_SCAN;
        end
      end
      ST_SCAN: begin
        cmd.scan_step = 1'b1;
        if (!status.is_insert || status.scan_done) begin
          state_next = status.id_zero ? ST_POOL_RD : ST_PROBE_RD;
        end
      end
      ST_PROBE_RD: begin
        cmd.probe_read = 1'b1;
        state_next     = ST_PROBE_CHK;
      end
      ST_PROBE_CHK: begin
        if (status.probe_hit || status.probe_empty || status.probe_exhausted) begin
          state_next = ST_POOL_RD;
        end else begin
          cmd.probe_next = 1'b1;
          state_next     = ST_PROBE_RD;
        end
      end
      ST_POOL_RD: begin
        cmd.pool_read = 1'b1;
        state_next    = ST_POOL_WAIT;
      end
      ST_POOL_WAIT: state_next = ST_COMMIT;
      ST_COMMIT: begin
        cmd.commit = 1'b1;
        state_next = ST_OUT;
      end
      ST_OUT: begin
        if (!out_full || out_ready) begin
          cmd.out_load  = 1'b1;
          out_full_next = 1'b1;
          state_next    = ST_IDLE;
        end
      end
      default: state_next = ST_CLEAR;
    endcase
  end

  assign out_valid = out_full;

  a_no_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (state != ST_IDLE) |-> !in_ready) else $error("accept while busy");
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_full && !out_ready) |=> out_full) else $error("result dropped");
  a_load_only_free: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |-> (!out_full || out_ready)) else $error("result overwritten");
endmodule

// ===== rtl/hec_datapath.sv =====
`timescale 1ns / 1ps
module hec_datapath #(
  parameter int POOL_DEPTH  = hec_pkg::POOL_DEPTH_D,
  parameter int TABLE_DEPTH = hec_pkg::TABLE_DEPTH_D,
  parameter int ID_WIDTH    = hec_pkg::ID_WIDTH_D,
  parameter int DATA_WIDTH  = hec_pkg::DATA_WIDTH_D,
  parameter int MAP_WORD    = hec_pkg::MAP_WORD_D
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic [hec_pkg::PERIOD_W-1:0]  cfg_data,
  input  logic [hec_pkg::CMD_W-1:0]     command,
  input  logic [ID_WIDTH-1:0]           elem_id,
  input  logic [DATA_WIDTH-1:0]         payload,
  input  hec_pkg::hec_cmd_t             cmd,
  output hec_pkg::hec_status_t          status,
  output logic                          success,
  output logic [hec_pkg::SLOT_W-1:0]    slot_index,
  output logic [DATA_WIDTH-1:0]         data_out
);
  import hec_pkg::*;

  localparam int PW       = $clog2(POOL_DEPTH);
  localparam int TW       = $clog2(TABLE_DEPTH);
  localparam int MAP_WORDS = (POOL_DEPTH + MAP_WORD - 1) / MAP_WORD;
  localparam int WB       = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
  localparam int KW       = $clog2(MAP_WORD) + 1;
  localparam int CW       = PW + 2;

  logic [ID_WIDTH-1:0]   bucket_ids   [TABLE_DEPTH];
  logic [PW-1:0]         bucket_slots [TABLE_DEPTH];
  logic [DATA_WIDTH-1:0] pool_data    [POOL_DEPTH];
  logic [POOL_DEPTH-1:0] present, used;
  logic [PERIOD_W-1:0]   aging_period, insert_counter;

  logic [TW:0]           clear_ptr;
  logic                  is_ins;
  logic [ID_WIDTH-1:0]   id;
  logic [DATA_WIDTH-1:0] data;
  logic [WB:0]           word;
  logic                  found;
  logic [PW-1:0]         slot;
  logic [TW-1:0]         pos;
  logic [TW:0]           probes;
  logic [ID_WIDTH-1:0]   rd_id;
  logic [PW-1:0]         rd_slot;
  logic [DATA_WIDTH-1:0] pool_rd;
  logic                  r_ok;
  logic [PW-1:0]         r_slot;

  logic [CW-1:0] cand;
  logic [CW-1:0] base;
  logic [PW-1:0] hit_slot;

  always_comb begin
    base = CW'(word[WB-1:0]) * CW'(MAP_WORD);
    cand = base;
    for (int k = 0; k < MAP_WORD; k++) begin
      if ((base + CW'(k)) < CW'(POOL_DEPTH) && present[PW'(base + CW'(k))])
        cand = base + CW'(k) + CW'(1);
    end
  end

  assign hit_slot = rd_slot;

  always_ff @(posedge clk) begin
    if (rst) begin
      clear_ptr      <= '0;
      present        <= '0;
      used           <= '0;
      insert_counter <= '0;
      aging_period   <= AGING_RESET;
    end else begin
      if (cfg_we) aging_period <= cfg_data;
      if (cmd.clear_step && !clear_ptr[TW]) clear_ptr <= clear_ptr + 1'b1;
      if (cmd.commit) begin
        if (is_ins) begin
          if (insert_counter >= aging_period) begin
            present        <= (present & used) | (POOL_DEPTH'(1) << slot);
            used           <= '0;
            insert_counter <= '0;
          end else begin
            present[slot]  <= 1'b1;
            used[slot]     <= 1'b1;
            insert_counter <= insert_counter + 1'b1;
          end
        end else if (r_ok) begin
          used[r_slot] <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.clear_step && !clear_ptr[TW]) begin
      bucket_ids[clear_ptr[TW-1:0]]   <= '0;
      bucket_slots[clear_ptr[TW-1:0]] <= '0;
    end else if (cmd.commit && is_ins && r_ok) begin
      bucket_ids[pos]   <= id;
      bucket_slots[pos] <= slot;
    end
    if (cmd.probe_read) begin
      rd_id   <= bucket_ids[pos];
      rd_slot <= bucket_slots[pos];
    end
    if (cmd.commit && is_ins) pool_data[slot] <= data;
    if (cmd.pool_read) pool_rd <= pool_data[hit_slot];
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      is_ins <= (command == CMD_INSERT);
      id     <= elem_id;
      data   <= payload;
      word   <= '0;
      found  <= 1'b0;
      slot   <= '0;
      pos    <= TW'(elem_id % TABLE_DEPTH);
      probes <= '0;
    end
    if (cmd.scan_step && is_ins && !found && !word[WB] &&
        word[WB-1:0] <= WB'(MAP_WORDS - 1)) begin
      if (cand < CW'(POOL_DEPTH) && !present[PW'(cand)]) begin
        found <= 1'b1;
        slot  <= PW'(cand);
      end
      word <= word + 1'b1;
    end
    if (cmd.probe_read) probes <= probes + 1'b1;
    if (cmd.probe_next) pos <= pos + 1'b1;
  end

  always_ff @(posedge clk) begin
    if (cmd.pool_read) begin
      r_ok   <= !status.id_zero && (rd_id == id || (is_ins && rd_id == '0)) &&
                (is_ins || present[rd_slot]);
      r_slot <= is_ins ? slot : rd_slot;
    end
    if (cmd.out_load) begin
      success    <= r_ok;
      slot_index <= (is_ins || r_ok) ? SLOT_W'(r_slot) : '0;
      data_out   <= is_ins ? data : (r_ok ? pool_rd : '0);
    end
  end

  assign status.clear_done      = clear_ptr[TW];
  assign status.scan_done       = found || (word >= (WB+1)'(MAP_WORDS));
  assign status.probe_hit       = (rd_id == id);
  assign status.probe_empty     = (rd_id == '0);
  assign status.probe_exhausted = (probes >= (TW+1)'(TABLE_DEPTH));
  assign status.is_insert       = is_ins;
  assign status.id_zero         = (id == '0);

  a_slot_range: assert property (@(posedge clk) disable iff (rst)
    cmd.commit |-> (32'(slot) < POOL_DEPTH)) else $error("slot out of pool");
  a_probe_bound: assert property (@(posedge clk) disable iff (rst)
    cmd.probe_read |-> (probes < (TW+1)'(TABLE_DEPTH))) else $error("probe overrun");
  a_clear_once: assert property (@(posedge clk) disable iff (rst)
    status.clear_done |=> status.clear_done) else $error("clear restarted");
endmodule

// ===== rtl/hashed_element_cache_with_aging_core.sv =====
`timescale 1ns / 1ps
// Hash cache with ageing: search (command 0) or insert (command 1) by elem_id.
// Input channel: in_valid/in_ready with command, elem_id, payload.
// Output channel: out_valid/out_ready with success, slot_index, data_out.
// One result per transaction, in order.
// cfg_we/cfg_data write aging_period at any idle cycle.
// Steps: accept in the idle state, then the scan state, which a search passes
// straight through and an insert holds for the free-slot scan, one map word
// a step; each then walks the bucket table with a read and a check per probed
// bucket (single-port bucket memory), then pool read, wait, commit and output
// load. One transaction is in flight at a time.
// After reset a clearing pass empties the bucket table, one bucket a cycle,
// before in_ready rises.
// The result sits in an output register; while the receiver stalls, the
// next transaction may be accepted and worked up to the output stage,
// where it holds until the register frees.
module hashed_element_cache_with_aging_core #(
  parameter int POOL_DEPTH  = hec_pkg::POOL_DEPTH_D,
  parameter int TABLE_DEPTH = hec_pkg::TABLE_DEPTH_D,
  parameter int ID_WIDTH    = hec_pkg::ID_WIDTH_D,
  parameter int DATA_WIDTH  = hec_pkg::DATA_WIDTH_D,
  parameter int MAP_WORD    = hec_pkg::MAP_WORD_D
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cfg_we,
  input  logic [hec_pkg::PERIOD_W-1:0] cfg_data,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [hec_pkg::CMD_W-1:0]    command,
  input  logic [ID_WIDTH-1:0]          elem_id,
  input  logic [DATA_WIDTH-1:0]        payload,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic                         success,
  output logic [hec_pkg::SLOT_W-1:0]   slot_index,
  output logic [DATA_WIDTH-1:0]        data_out
);
  import hec_pkg::*;

  hec_cmd_t    cmd;
  hec_status_t status;

  hec_ctrl u_ctrl (
    .clk, .rst, .in_valid, .in_ready, .out_valid, .out_ready, .status, .cmd
  );

  hec_datapath #(
    .POOL_DEPTH(POOL_DEPTH), .TABLE_DEPTH(TABLE_DEPTH), .ID_WIDTH(ID_WIDTH),
    .DATA_WIDTH(DATA_WIDTH), .MAP_WORD(MAP_WORD)
  ) u_dp (
    .clk, .rst, .cfg_we, .cfg_data, .command, .elem_id, .payload,
    .cmd, .status, .success, .slot_index, .data_out
  );
endmodule

// ===== tb/sv/hashed_element_cache_with_aging_core_tb.sv =====
`timescale 1ns / 1ps
module hashed_element_cache_with_aging_core_tb;
  import hec_pkg::*;

  localparam int POOL  = POOL_DEPTH_D;
  localparam int TDEP  = TABLE_DEPTH_D;
  localparam int MWORD = MAP_WORD_D;
  localparam int MWORDS = (POOL + MWORD - 1) / MWORD;
  localparam longint CYCLE_LIMIT = 5000000;

  typedef struct {
    logic        success;
    logic [7:0]  slot;
    logic [63:0] data;
  } cache_result_t;

  class cache_scoreboard;
    logic [31:0] bucket_id [TDEP];
    logic [7:0]  bucket_slot [TDEP];
    logic [63:0] pool_data [POOL];
    bit          present [POOL];
    bit          used [POOL];
    int unsigned insert_count;
    logic [15:0] period;
    cache_result_t pending_results[$];
    int errors;

    function new();
      foreach (bucket_id[i]) begin
        bucket_id[i] = '0;
        bucket_slot[i] = '0;
      end
      foreach (pool_data[i]) begin
        pool_data[i] = '0;
        present[i] = 0;
        used[i] = 0;
      end
      insert_count = 0;
      period = AGING_RESET;
      errors = 0;
    endfunction

    function bit find_bucket(logic [31:0] id, output int pos);
      int start;
      int idx;
      start = id % TDEP;
      for (int x = 0; x < TDEP; x++) begin
        idx = (start + x) % TDEP;
        if (bucket_id[idx] == 0 || bucket_id[idx] == id) begin
          pos = idx;
          return 1;
        end
      end
      pos = 0;
      return 0;
    endfunction

    function int pick_slot();
      int base;
      int cand;
      for (int b = 0; b < MWORDS; b++) begin
        base = b * MWORD;
        cand = base;
        for (int k = 0; k < MWORD; k++)
          if (base + k < POOL && present[base + k]) cand = base + k + 1;
        if (cand < POOL && !present[cand]) return cand;
      end
      return 0;
    endfunction

    function void note_request(logic cmd, logic [31:0] id, logic [63:0] pl);
      cache_result_t r;
      int pos;
      int s;
      r.success = 0;
      r.slot = '0;
      r.data = '0;
      if (cmd == CMD_SEARCH) begin
        if (id != 0 && find_bucket(id, pos) && bucket_id[pos] == id) begin
          s = bucket_slot[pos] % POOL;
          if (present[s]) begin
            used[s] = 1;
            r.success = 1;
            r.slot = s[7:0];
            r.data = pool_data[s];
          end
        end
      end else begin
        s = pick_slot();
        present[s] = 1;
        used[s] = 1;
        if (insert_count >= period) begin
          for (int i = 0; i < POOL; i++) begin
            present[i] = present[i] & used[i];
            used[i] = 0;
          end
          insert_count = 0;
        end else begin
          insert_count = (insert_count + 1) & 16'hFFFF;
        end
        pool_data[s] = pl;
        if (id != 0 && find_bucket(id, pos)) begin
          bucket_id[pos] = id;
          bucket_slot[pos] = s[7:0];
          r.success = 1;
        end
        r.slot = s[7:0];
        r.data = pl;
      end
      pending_results.push_back(r);
    endfunction

    function void check_result(logic ok, logic [7:0] slot, logic [63:0] d);
      cache_result_t e;
      if (pending_results.size() == 0) begin
        $error("unexpected result: success=%0d slot_index=%0d data_out=%h", ok, slot, d);
        errors++;
        return;
      end
      e = pending_results.pop_front();
      if (ok !== e.success) begin
        $error("success: expected %0d, actual %0d", e.success, ok);
        errors++;
      end
      if (slot !== e.slot) begin
        $error("slot_index: expected %0d, actual %0d", e.slot, slot);
        errors++;
      end
      if (d !== e.data) begin
        $error("data_out: expected %h, actual %h", e.data, d);
        errors++;
      end
    endfunction
  endclass

  logic        clk;
  logic        rst;
  logic        cfg_we;
  logic [15:0] cfg_data;
  logic        in_valid;
  logic        in_ready;
  logic        command;
  logic [31:0] elem_id;
  logic [63:0] payload;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic        success;
  logic [7:0]  slot_index;
  logic [63:0] data_out;

  cache_scoreboard sb = new();
  int  send_idle_pct;
  int  recv_stall_pct;
  bit  hold_req;
  bit  hold_done = 0;
  int  hold_left = 0;
  longint cycles = 0;

  hashed_element_cache_with_aging_core u_dut (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_ready(in_ready), .command(command),
    .elem_id(elem_id), .payload(payload), .out_valid(out_valid),
    .out_ready(out_ready), .success(success), .slot_index(slot_index),
    .data_out(data_out)
  );

  initial begin
    clk = 0;
    forever #4 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready)
      sb.check_result(success, slot_index, data_out);
    if (hold_req && !hold_done) begin
      hold_left = 400;
      hold_done = 1;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ready <= 0;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  task automatic send_request(logic cmd, logic [31:0] id, logic [63:0] pl);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 0;
      @(posedge clk);
    end
    in_valid <= 1;
    command <= cmd;
    elem_id <= id;
    payload <= pl;
    do @(posedge clk); while (!in_ready);
    sb.note_request(cmd, id, pl);
  endtask

  task automatic wait_drained();
    in_valid <= 0;
    while (sb.pending_results.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic write_period(logic [15:0] v);
    wait_drained();
    cfg_we <= 1;
    cfg_data <= v;
    @(posedge clk);
    sb.period = v;
    cfg_we <= 0;
    @(posedge clk);
  endtask

  function automatic logic [31:0] random_id();
    case ($urandom_range(9))
      0: return $urandom();
      1: return 32'hFFFF_FFFF - $urandom_range(3) * TDEP;
      default: return $urandom_range(1, 60) + TDEP * $urandom_range(0, 5);
    endcase
  endfunction

  task automatic random_phase(int n);
    logic [31:0] id;
    for (int i = 0; i < n; i++) begin
      id = random_id();
      send_request($urandom_range(99) < 45 ? CMD_INSERT : CMD_SEARCH, id,
                   {$urandom(), $urandom()});
    end
  endtask

  initial begin
    rst = 1;
    cfg_we = 0;
    cfg_data = '0;
    in_valid = 0;
    command = CMD_SEARCH;
    elem_id = '0;
    payload = '0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    hold_req = 0;
    repeat (4) @(posedge clk);
    rst <= 0;
    write_period(16'd3);

    send_request(CMD_SEARCH, 32'd5, '0);
    send_request(CMD_INSERT, 32'd5, 64'h0);
    send_request(CMD_SEARCH, 32'd5, '1);
    send_request(CMD_INSERT, 32'hFFFF_FFFF, '1);
    send_request(CMD_SEARCH, 32'hFFFF_FFFF, '0);
    send_request(CMD_INSERT, 32'd1, 64'hAAAA_AAAA_AAAA_AAAA);
    send_request(CMD_INSERT, 32'd1 + TDEP, 64'h5555_5555_5555_5555);
    send_request(CMD_INSERT, 32'd1 + 2 * TDEP, 64'h8000_0000_0000_0001);
    send_request(CMD_SEARCH, 32'd1 + TDEP, '0);
    send_request(CMD_SEARCH, 32'd1 + 2 * TDEP, '0);
    send_request(CMD_INSERT, 32'd0, 64'h1234_5678_9ABC_DEF0);
    send_request(CMD_SEARCH, 32'd0, '0);
    send_request(CMD_INSERT, 32'd5, 64'hDEAD_BEEF_0000_FFFF);
    send_request(CMD_SEARCH, 32'd5, '0);
    send_request(CMD_SEARCH, 32'd1, '0);
    send_request(CMD_INSERT, 32'd77, 64'h1);
    send_request(CMD_SEARCH, 32'd77, '0);
    send_request(CMD_SEARCH, 32'd511, '0);

    write_period(16'd1);
    hold_req = 1;
    random_phase(200);
    wait_drained();
    random_phase(10);

    write_period(16'd65535);
    send_idle_pct = 75;
    random_phase(240);

    write_period(16'd20);
    send_idle_pct = 0;
    recv_stall_pct = 75;
    random_phase(240);

    write_period(AGING_RESET);
    send_idle_pct = 28;
    recv_stall_pct = 28;
    random_phase(240);

    wait_drained();
    repeat (200) @(posedge clk);
    if (sb.errors == 0 && sb.pending_results.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end
endmodule
